### hdl/ncache_pkg.sv
// Package: action codes, status codes and payload types for the neighbor cache.
package ncache_pkg;
	localparam int unsigned AGING_W = 22;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned MAC_W = 48;
	localparam logic [AGING_W-1:0] AGING_RESET = 22'd900000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [2:0] ACT_LOOKUP = 3'd0;
	localparam logic [2:0] ACT_SET    = 3'd1;
	localparam logic [2:0] ACT_SWEEP  = 3'd2;
	localparam logic [2:0] ACT_FLUSHB = 3'd3;
	localparam logic [2:0] ACT_FLUSH  = 3'd4;
	localparam logic [2:0] ACT_CLAMP  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]        action;
		logic [7:0]        bridge;
		logic [63:0]       ip_high;
		logic [63:0]       ip_low;
		logic [MAC_W-1:0]  mac_in;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [MAC_W-1:0]  mac_out;
		logic [1:0]        status;
		logic              changed;
	} rsp_t;

	// Broadcast from the controller to every cell for one request.
	typedef struct packed {
		logic              cmp;      // compare stage: latch flags
		logic              wr;       // write stage: apply
		logic [2:0]        action;
		logic [7:0]        bridge;
		logic [63:0]       ip_high;
		logic [63:0]       ip_low;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] fresh;
	} bcast_t;

	// Per-cell flags handed to the controller.
	typedef struct packed {
		logic             match;  // valid and key equal
		logic             live;   // expiry above now
		logic             same_mac;
		logic             free;
		logic [MAC_W-1:0] mac;
	} cflag_t;
endpackage

### hdl/ncache_cell.sv
// One table entry: key, MAC and expiry, with compare and update logic.
module ncache_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ncache_pkg::bcast_t   bc,
	input  logic                 prior_in,   // an earlier cell claimed the request
	input  logic                 sel_key,    // write-stage: this cell holds the key
	input  logic                 sel_free,   // write-stage: this cell takes an insert
	output logic                 claim_out,  // prior_in or own match, for the key chain
	output logic                 key_first,
	output ncache_pkg::cflag_t   flag,
	output logic                 del
);
	logic                           valid_q;
	logic [7:0]                     bridge_q;
	logic [63:0]                    ip_high_q;
	logic [63:0]                    ip_low_q;
	logic [ncache_pkg::MAC_W-1:0]   mac_q;
	logic [ncache_pkg::TIME_W-1:0]  expiry_q;
	logic                           expired;

	assign expired = expiry_q <= bc.now_ms;
	assign flag.match = valid_q && bridge_q == bc.bridge && ip_high_q == bc.ip_high
		&& ip_low_q == bc.ip_low;
	assign flag.live = !expired;
	assign flag.same_mac = mac_q == bc.mac;
	assign flag.free = !valid_q;
	assign flag.mac = mac_q;

	// prior_in is a key-match chain when matching, free chain handled outside
	assign key_first = flag.match && !prior_in;
	assign claim_out = prior_in || flag.match;

	always_comb begin
		case (bc.action)
			ncache_pkg::ACT_SWEEP:  del = valid_q && expired;
			ncache_pkg::ACT_FLUSHB: del = valid_q && bridge_q == bc.bridge;
			ncache_pkg::ACT_FLUSH:  del = valid_q;
			default:                del = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.wr) begin
			if (del)
				valid_q <= 1'b0;
			else if (sel_free)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.wr) begin
			if (sel_free) begin
				bridge_q <= bc.bridge;
				ip_high_q <= bc.ip_high;
				ip_low_q <= bc.ip_low;
				mac_q <= bc.mac;
				expiry_q <= bc.fresh;
			end else if (sel_key) begin
				if (bc.action == ncache_pkg::ACT_SET)
					mac_q <= bc.mac;
				expiry_q <= bc.fresh;
			end else if (bc.action == ncache_pkg::ACT_CLAMP && valid_q
				&& bc.fresh < expiry_q) begin
				expiry_q <= bc.fresh;
			end
		end
	end
endmodule

### hdl/neighbor_cache_with_aging.sv
// Neighbor cache top level: a row of ENTRIES cells, request controller and result register.
// In the compare stage of a request all cells compare their entries with the request's key,
// bridge and time in parallel, ripple priority chains along the row pick the lowest
// matching and free cells, and the flags are registered; then in the write stage all cells
// apply the update. A new request is taken once the result register is free.
module neighbor_cache_with_aging #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ncache_pkg::req_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ncache_pkg::rsp_t                out_data,
	input  logic                            cfg_we,
	input  logic [ncache_pkg::AGING_W-1:0]  cfg_wdata
);
	logic [ncache_pkg::AGING_W-1:0] aging_q;
	ncache_pkg::req_t               req_q;
	logic                           busy_q;
	logic                           phase_q;
	ncache_pkg::bcast_t             bc;
	ncache_pkg::cflag_t             flag [ENTRIES];
	logic [ENTRIES:0]               kchain;
	logic [ENTRIES:0]               fchain;
	logic [ENTRIES-1:0]             key_first, del, sel_key, sel_free;
	logic [ENTRIES-1:0]             key_first_s1, free_first_s1;
	logic [ENTRIES:0]               fclaim;
	logic [ncache_pkg::TIME_W:0]    sum;
	logic                           any_key, any_free, do_ins, do_key;
	logic [ncache_pkg::MAC_W-1:0]   kmac;
	logic                           klive, ksame;
	logic                           klive_s1, ksame_s1, any_key_s1, any_free_s1, any_del_s1;
	logic [ncache_pkg::MAC_W-1:0]   kmac_s1;
	ncache_pkg::rsp_t               rsp;

	assign sum = {1'b0, req_q.now_ms} + {{(ncache_pkg::TIME_W-ncache_pkg::AGING_W+1){1'b0}},
		aging_q};
	assign in_ready = !busy_q && !out_valid;

	always_comb begin
		bc.cmp = busy_q && !phase_q;
		bc.wr = busy_q && phase_q;
		bc.action = req_q.action;
		bc.bridge = req_q.bridge;
		bc.ip_high = req_q.ip_high;
		bc.ip_low = req_q.ip_low;
		bc.mac = req_q.mac_in;
		bc.now_ms = req_q.now_ms;
		bc.fresh = sum[ncache_pkg::TIME_W] ? ncache_pkg::TIME_MAX
			: sum[ncache_pkg::TIME_W-1:0];
	end

	assign kchain[0] = 1'b0;
	assign fchain[0] = 1'b0;
	assign fclaim[0] = 1'b0;
	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			ncache_cell u_cell (
				.clk(clk), .arst_n(arst_n), .bc(bc),
				.prior_in(kchain[g]), .sel_key(sel_key[g]), .sel_free(sel_free[g]),
				.claim_out(kchain[g+1]), .key_first(key_first[g]),
				.flag(flag[g]), .del(del[g])
			);
			// free slot priority chain, resolved in the compare stage and then registered
			assign fchain[g+1] = fchain[g] || flag[g].free;
			assign fclaim[g+1] = fclaim[g] || (flag[g].free && !fchain[g]);
			assign sel_key[g] = bc.wr && do_key && key_first_s1[g];
			assign sel_free[g] = bc.wr && do_ins && free_first_s1[g];
		end
	endgenerate

	always_comb begin
		kmac = '0;
		klive = 1'b0;
		ksame = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (key_first[i]) begin
				kmac = kmac | flag[i].mac;
				klive = klive | flag[i].live;
				ksame = ksame | flag[i].same_mac;
			end
		end
	end
	assign any_key = kchain[ENTRIES];
	assign any_free = fchain[ENTRIES];

	// write-stage decisions on the registered compare results
	always_comb begin
		do_key = 1'b0;
		do_ins = 1'b0;
		rsp = '0;
		case (req_q.action)
			ncache_pkg::ACT_LOOKUP: begin
				do_key = any_key_s1 && klive_s1;
				rsp.hit = do_key;
				rsp.mac_out = do_key ? kmac_s1 : '0;
				rsp.status = do_key ? ncache_pkg::ST_OK : ncache_pkg::ST_MISS;
			end
			ncache_pkg::ACT_SET: begin
				do_key = any_key_s1;
				do_ins = !any_key_s1 && any_free_s1;
				rsp.changed = any_key_s1 ? (!klive_s1 || !ksame_s1) : any_free_s1;
				rsp.status = (!any_key_s1 && !any_free_s1) ? ncache_pkg::ST_FULL
					: ncache_pkg::ST_OK;
			end
			ncache_pkg::ACT_SWEEP, ncache_pkg::ACT_FLUSHB, ncache_pkg::ACT_FLUSH:
				rsp.changed = any_del_s1;
			default: rsp = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bc.cmp) begin
			key_first_s1 <= key_first;
			for (int i = 0; i < ENTRIES; i++)
				free_first_s1[i] <= fclaim[i+1] && !fclaim[i];
			any_key_s1 <= any_key;
			any_free_s1 <= any_free;
			any_del_s1 <= |del;
			kmac_s1 <= kmac;
			klive_s1 <= klive;
			ksame_s1 <= ksame;
		end
		if (in_valid && in_ready)
			req_q <= in_data;
		if (bc.wr)
			out_data <= rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_q <= ncache_pkg::AGING_RESET;
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				aging_q <= cfg_wdata;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				phase_q <= 1'b0;
				out_valid <= 1'b1;
			end
		end
	end
endmodule
